// ===== sv/two_body_gravity_step_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-body gravity step block
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_BODY_GRAVITY_STEP_TOP_ASSERT_SVH
`define TWO_BODY_GRAVITY_STEP_TOP_ASSERT_SVH

// same-cycle implication under reset
`define TBG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbg assertion failed");

// next-cycle implication under reset
`define TBG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbg assertion failed");

`endif

// ===== sv/tbg_pkg.sv =====
// ----------------------------------------------------------------------------
// tbg_pkg
// Types, constants and helpers of the two-body gravity step block.
// ----------------------------------------------------------------------------
package tbg_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int VAL_W         = 64;
  localparam int MU_W          = 63;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_MU_FIRST  = 1'b0;
  localparam logic REG_MU_SECOND = 1'b1;

  localparam logic [VAL_W-1:0] SIGN_MASK = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] MAX_POS   = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_DEN,
    ST_KSET,
    ST_NUM,
    ST_OVF,
    ST_DIV,
    ST_KICK,
    ST_POS,
    ST_DONE
  } state_t;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] r;
    r = a + b;
    if (((a ^ b) & SIGN_MASK) == '0 && ((a ^ r) & SIGN_MASK) != '0) begin
      r = a[VAL_W-1] ? SIGN_MASK : MAX_POS;
    end
    return r;
  endfunction

endpackage

// ===== sv/two_body_gravity_step_top.sv =====
// ----------------------------------------------------------------------------
// two_body_gravity_step_top
// One semi-implicit Euler tick of two point masses in 64-bit fixed point.
// ----------------------------------------------------------------------------
// A load item (cmd 0) writes one body's state and gives no result. A tick
// item (cmd 1) runs to completion before the next item is accepted: every
// squaring, root, product and quotient runs one bit per cycle through a single
// shared wide adder/subtractor (2 x 64 squaring steps, 65 root steps, 65 steps
// for the denominator, then per velocity component 63 multiply and 64 divide
// steps). Coincident positions skip the arithmetic. The input side is not
// ready while a tick is in progress; the result sits in an output register
// until taken.
module two_body_gravity_step_top #(
  parameter int FRAC_BITS = tbg_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // load_pos_x, load_pos_y, load_vel_x, load_vel_y
  input  logic [255:0] in_tdata,
  // cmd, body_sel
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // first_pos_x, first_pos_y, second_pos_x, second_pos_y,
  // first_vel_x, first_vel_y, second_vel_x, second_vel_y
  output logic [511:0] out_tdata,
  // coincident
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [62:0]  cfg_data
);
  import tbg_pkg::*;

  localparam int SH    = 3 * FRAC_BITS;
  localparam int NUM_W = VAL_W + MU_W + SH;
  localparam int DEN_W = 195;
  localparam int S_W   = 130;
  localparam int W     = ((NUM_W > DEN_W + VAL_W) ? NUM_W : DEN_W + VAL_W) + 1;

  localparam logic [6:0] CNT_SQ   = 7'd63;
  localparam logic [6:0] CNT_ROOT = 7'd64;
  localparam logic [6:0] CNT_MU   = 7'd62;
  localparam logic [6:0] CNT_DIV  = 7'd63;

  state_t state_r, state_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [1:0]       kick_r, kick_nxt;
  logic [VAL_W-1:0] pos_x_r [2], pos_x_nxt [2];
  logic [VAL_W-1:0] pos_y_r [2], pos_y_nxt [2];
  logic [VAL_W-1:0] vel_x_r [2], vel_x_nxt [2];
  logic [VAL_W-1:0] vel_y_r [2], vel_y_nxt [2];
  logic [MU_W-1:0]  mu_first_r, mu_second_r;
  logic [VAL_W-1:0] mag_x_r, mag_x_nxt, mag_y_r, mag_y_nxt;
  logic             neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [S_W-1:0]   s_r, s_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [W-1:0]     acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [64:0]      mplier_r, mplier_nxt;
  logic [VAL_W-1:0] q_r, q_nxt;
  logic             over_r, over_nxt, coin_r, coin_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [511:0]     out_data_r, out_data_nxt;
  logic             out_coin_r, out_coin_nxt;

  logic [W-1:0]     add_a, add_b;
  logic             add_sub;
  logic [W:0]       add_full;
  logic [W-1:0]     add_sum;
  logic             add_co;

  logic [VAL_W-1:0] ox, sx, oy, sy, sp_mx, sp_my;
  logic             sp_nx, sp_ny;
  logic             k_neg;
  logic [VAL_W-1:0] k_v, k_lim, k_delta;

  // shared unit operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      ST_SQX, ST_SQY, ST_DEN, ST_NUM: begin
        add_a = acc_r;
        add_b = mplier_r[0] ? mcand_r : '0;
      end
      ST_ROOT: begin
        add_a   = {acc_r[W-3:0], mcand_r[S_W-1:S_W-2]};
        add_b   = W'({mplier_r, 2'b01});
        add_sub = 1'b1;
      end
      ST_OVF: begin
        add_a   = acc_r << SH;
        add_b   = W'(den_r) << VAL_W;
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_a   = {acc_r[W-2:0], mplier_r[VAL_W-1]};
        add_b   = W'(den_r);
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_full = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} +
                    {{W{1'b0}}, add_sub};
  assign add_sum  = add_full[W-1:0];
  assign add_co   = add_full[W];

  always_comb begin
    ox    = pos_x_r[1] ^ SIGN_MASK;
    sx    = pos_x_r[0] ^ SIGN_MASK;
    oy    = pos_y_r[1] ^ SIGN_MASK;
    sy    = pos_y_r[0] ^ SIGN_MASK;
    sp_nx = ox < sx;
    sp_ny = oy < sy;
    sp_mx = sp_nx ? (sx - ox) : (ox - sx);
    sp_my = sp_ny ? (sy - oy) : (oy - sy);
    k_neg = (kick_r[0] ? neg_y_r : neg_x_r) ^ kick_r[1];
    k_lim = k_neg ? SIGN_MASK : MAX_POS;
    k_v   = (over_r || q_r > k_lim) ? k_lim : q_r;
    k_delta = k_neg ? (~k_v + 64'd1) : k_v;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kick_nxt      = kick_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    vel_x_nxt     = vel_x_r;
    vel_y_nxt     = vel_y_r;
    mag_x_nxt     = mag_x_r;
    mag_y_nxt     = mag_y_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    s_nxt         = s_r;
    den_nxt       = den_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    q_nxt         = q_r;
    over_nxt      = over_r;
    coin_nxt      = coin_r;
    out_data_nxt  = out_data_r;
    out_coin_nxt  = out_coin_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == CMD_LOAD) begin
            pos_x_nxt[in_tuser[1]] = in_tdata[63:0];
            pos_y_nxt[in_tuser[1]] = in_tdata[127:64];
            vel_x_nxt[in_tuser[1]] = in_tdata[191:128];
            vel_y_nxt[in_tuser[1]] = in_tdata[255:192];
          end else begin
            state_nxt = ST_SPAN;
          end
        end
      end
      ST_SPAN: begin
        mag_x_nxt = sp_mx;
        mag_y_nxt = sp_my;
        neg_x_nxt = sp_nx;
        neg_y_nxt = sp_ny;
        if (sp_mx == '0 && sp_my == '0) begin
          coin_nxt  = 1'b1;
          state_nxt = ST_POS;
        end else begin
          coin_nxt   = 1'b0;
          acc_nxt    = '0;
          mcand_nxt  = W'(sp_mx);
          mplier_nxt = 65'(sp_mx);
          cnt_nxt    = CNT_SQ;
          state_nxt  = ST_SQX;
        end
      end
      ST_SQX, ST_SQY, ST_DEN, ST_NUM: begin
        acc_nxt    = add_sum;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          unique case (state_r)
            ST_SQX: begin
              mcand_nxt  = W'(mag_y_r);
              mplier_nxt = 65'(mag_y_r);
              cnt_nxt    = CNT_SQ;
              state_nxt  = ST_SQY;
            end
            ST_SQY: begin
              s_nxt      = add_sum[S_W-1:0];
              mcand_nxt  = W'(add_sum[S_W-1:0]);
              acc_nxt    = '0;
              mplier_nxt = '0;
              cnt_nxt    = CNT_ROOT;
              state_nxt  = ST_ROOT;
            end
            ST_DEN: begin
              den_nxt   = add_sum[DEN_W-1:0];
              kick_nxt  = '0;
              state_nxt = ST_KSET;
            end
            default: begin
              state_nxt = ST_OVF;
            end
          endcase
        end
      end
      ST_ROOT: begin
        mcand_nxt = mcand_r << 2;
        if (add_co) begin
          acc_nxt    = add_sum;
          mplier_nxt = {mplier_r[63:0], 1'b1};
        end else begin
          acc_nxt    = add_a;
          mplier_nxt = {mplier_r[63:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          acc_nxt   = '0;
          mcand_nxt = W'(s_r);
          cnt_nxt   = CNT_ROOT;
          state_nxt = ST_DEN;
        end
      end
      ST_KSET: begin
        acc_nxt    = '0;
        mcand_nxt  = W'(kick_r[0] ? mag_y_r : mag_x_r);
        mplier_nxt = 65'(kick_r[1] ? mu_first_r : mu_second_r);
        cnt_nxt    = CNT_MU;
        state_nxt  = ST_NUM;
      end
      ST_OVF: begin
        over_nxt   = add_co;
        acc_nxt    = add_a >> VAL_W;
        mplier_nxt = 65'(add_a[VAL_W-1:0]);
        q_nxt      = '0;
        cnt_nxt    = CNT_DIV;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        mplier_nxt = mplier_r << 1;
        if (add_co) begin
          acc_nxt = add_sum;
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          acc_nxt = add_a;
          q_nxt   = {q_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_KICK;
        end
      end
      ST_KICK: begin
        if (kick_r[0]) begin
          vel_y_nxt[kick_r[1]] = sat_add(vel_y_r[kick_r[1]], k_delta);
        end else begin
          vel_x_nxt[kick_r[1]] = sat_add(vel_x_r[kick_r[1]], k_delta);
        end
        kick_nxt  = kick_r + 2'd1;
        state_nxt = (kick_r == 2'd3) ? ST_POS : ST_KSET;
      end
      ST_POS: begin
        for (int b = 0; b < 2; b++) begin
          pos_x_nxt[b] = sat_add(pos_x_r[b], vel_x_r[b]);
          pos_y_nxt[b] = sat_add(pos_y_r[b], vel_y_r[b]);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {vel_y_r[1], vel_x_r[1], vel_y_r[0], vel_x_r[0],
                           pos_y_r[1], pos_x_r[1], pos_y_r[0], pos_x_r[0]};
          out_coin_nxt  = coin_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mu_first_r  <= '0;
      mu_second_r <= '0;
      pos_x_r     <= '{default: '0};
      pos_y_r     <= '{default: '0};
      vel_x_r     <= '{default: '0};
      vel_y_r     <= '{default: '0};
      cnt_r       <= '0;
      kick_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      vel_x_r     <= vel_x_nxt;
      vel_y_r     <= vel_y_nxt;
      cnt_r       <= cnt_nxt;
      kick_r      <= kick_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_MU_FIRST) begin
          mu_first_r <= cfg_data;
        end else if (cfg_index == REG_MU_SECOND) begin
          mu_second_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_x_r    <= mag_x_nxt;
    mag_y_r    <= mag_y_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    s_r        <= s_nxt;
    den_r      <= den_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    q_r        <= q_nxt;
    over_r     <= over_nxt;
    coin_r     <= coin_nxt;
    out_data_r <= out_data_nxt;
    out_coin_r <= out_coin_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_coin_r;

endmodule

// ===== sv/tbg_checker.sv =====
// ----------------------------------------------------------------------------
// tbg_checker
// Port-level checks of the two-body gravity step block, bound to the top.
// ----------------------------------------------------------------------------
`include "two_body_gravity_step_top_assert.svh"

module tbg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [511:0] out_tdata
);
  import tbg_pkg::*;

  `TBG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `TBG_ASSERT_NEXT(a_tick_busy, in_tvalid && in_tready && in_tuser[0] == CMD_TICK, !in_tready)
  `TBG_ASSERT_NEXT(a_load_quiet, in_tvalid && in_tready && in_tuser[0] == CMD_LOAD && !out_tvalid, !out_tvalid)

endmodule

bind two_body_gravity_step_top tbg_checker u_tbg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
